// ----- rtl/rdm_pkg.sv -----
// Shared types, constants and calendar helpers for the rule day-of-month resolver.
`default_nettype none

package rdm_pkg;

  localparam int unsigned YearW      = 14;
  localparam int unsigned MonthW     = 4;
  localparam int unsigned WdayW      = 3;
  localparam int unsigned DrawW      = 6;
  localparam int unsigned DayW       = 5;
  localparam int unsigned QyW        = 8;
  localparam int unsigned YyW        = 15;
  localparam int unsigned FoldW      = 6;

  localparam int unsigned DaysPerWeek = 7;
  localparam int unsigned LastSpan    = 6;
  localparam int unsigned YearRecip   = 5243;   // ceil(2^19 / 100)
  localparam int unsigned RecipShift  = 19;
  localparam int unsigned ProdW       = YearW + 13;
  localparam int unsigned YearOffset  = 4800;
  localparam int unsigned CentBias    = YearOffset / 100;
  localparam int unsigned CentPad     = 217;    // multiple of 7 above any century count
  localparam int unsigned JdnAdj      = 1;      // -32045 mod 7

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month_in;
    logic [MonthW-1:0] month_sat;
    logic [WdayW-1:0]  wday;
    logic [DrawW-1:0]  draw;
  } rdm_req_t;

  typedef struct packed {
    logic              exact;
    logic              backward;
    logic [MonthW-1:0] month_in;
    logic [MonthW-1:0] month_sat;
    logic [DayW-1:0]   draw_lo;
    logic [WdayW-1:0]  wday;
    logic [DayW-1:0]   lim;
    logic [DayW-1:0]   dim;
    logic [DayW-1:0]   pdim;
  } rdm_ctx_t;

  typedef struct packed {
    rdm_ctx_t          ctx;
    logic [YyW-1:0]    yy;
    logic [QyW-1:0]    cent;
    logic [MonthW-1:0] mm;
  } rdm_date_t;

  typedef struct packed {
    rdm_ctx_t          ctx;
    logic [FoldW-1:0]  fold;
  } rdm_wk_t;

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] n;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = 5'd30;
      end
      MonthFeb: begin
        n = leap ? 5'd29 : 5'd28;
      end
      default: begin
        n = 5'd31;
      end
    endcase
    return n;
  endfunction

  // (153*mm + 2) / 5 reduced mod 7, mm counted from March
  function automatic logic [2:0] month_term(input logic [MonthW-1:0] mm);
    logic [2:0] t;
    case (mm)
      4'd0:    t = 3'd0;
      4'd1:    t = 3'd3;
      4'd2:    t = 3'd5;
      4'd3:    t = 3'd1;
      4'd4:    t = 3'd3;
      4'd5:    t = 3'd6;
      4'd6:    t = 3'd2;
      4'd7:    t = 3'd4;
      4'd8:    t = 3'd0;
      4'd9:    t = 3'd2;
      4'd10:   t = 3'd5;
      4'd11:   t = 3'd1;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rule_day_of_month_resolver_top.sv -----
// Top level of the rule day-of-month resolver pipeline.
//
//   channel   handshake          payload
//   request   start / busy       in_year, in_month, in_on_weekday, in_on_day
//   result    out_valid strobe   out_result_month, out_result_day
//
// Four register stages: capture and century split, leap and month lengths,
// day-number sum with octal fold, weekday shift and result register.
// A request is taken every cycle; its result strobes on out_valid once it has
// passed through all four register stages.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Synchronous active-low reset clears the stage valid bits only.
`default_nettype none

module rule_day_of_month_resolver_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  [13:0]       in_year,
  input  wire  [3:0]        in_month,
  input  wire  [2:0]        in_on_weekday,
  input  wire  signed [5:0] in_on_day,
  output logic              out_valid,
  output logic [3:0]        out_result_month,
  output logic [4:0]        out_result_day
);
  import rdm_pkg::*;

  logic      accept;
  rdm_req_t  req;
  logic      date_valid;
  rdm_date_t date;
  logic      wk_valid;
  rdm_wk_t   wk;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    req.year     = in_year;
    req.month_in = in_month;
    if (in_month == 4'd0) begin
      req.month_sat = 4'd1;
    end else if (in_month > MonthDec) begin
      req.month_sat = MonthDec;
    end else begin
      req.month_sat = in_month;
    end
    req.wday = in_on_weekday;
    req.draw = in_on_day;
  end

  rdm_date_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (accept),
    .req        (req),
    .date_valid (date_valid),
    .date       (date)
  );

  rdm_weekday u_weekday (
    .clk        (clk),
    .rst_n      (rst_n),
    .date_valid (date_valid),
    .date       (date),
    .wk_valid   (wk_valid),
    .wk         (wk)
  );

  rdm_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (wk_valid),
    .wk        (wk),
    .res_valid (out_valid),
    .res_month (out_result_month),
    .res_day   (out_result_day)
  );

endmodule

`default_nettype wire

// ----- rtl/rdm_date_prep.sv -----
// Request capture, century split, leap year, month lengths and day limit.
`default_nettype none

module rdm_date_prep (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         req_valid,
  input  rdm_pkg::rdm_req_t           req,
  output logic                        date_valid,
  output rdm_pkg::rdm_date_t          date
);
  import rdm_pkg::*;

  logic [ProdW-1:0]  prod;
  logic              s1_valid_r;
  rdm_req_t          s1_req_r;
  logic [QyW-1:0]    s1_qy_r;

  logic [YearW-1:0]  hund;
  logic [6:0]        rem;
  logic              leap;
  logic              early;
  logic [DayW-1:0]   dim;
  logic [DayW-1:0]   mag;
  rdm_date_t         date_nxt;
  logic              s2_valid_r;
  rdm_date_t         s2_date_r;

  assign prod = ProdW'(req.year) * ProdW'(YearRecip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r <= req;
    s1_qy_r  <= prod[RecipShift +: QyW];
  end

  always_comb begin
    hund  = YearW'(s1_qy_r) * YearW'(100);
    rem   = 7'(s1_req_r.year - hund);
    leap  = (s1_req_r.year[1:0] == 2'd0) && ((rem != 7'd0) || (s1_qy_r[1:0] == 2'd0));
    early = (s1_req_r.month_sat <= MonthFeb);
    dim   = days_in_month(s1_req_r.month_sat, leap);
    if (s1_req_r.draw == 6'b100000) begin
      mag = 5'd31;
    end else begin
      mag = 5'(6'd0 - s1_req_r.draw);
    end

    date_nxt.ctx.exact     = (s1_req_r.wday == 3'd0);
    date_nxt.ctx.backward  = s1_req_r.draw[DrawW-1];
    date_nxt.ctx.month_in  = s1_req_r.month_in;
    date_nxt.ctx.month_sat = s1_req_r.month_sat;
    date_nxt.ctx.draw_lo   = s1_req_r.draw[DayW-1:0];
    date_nxt.ctx.wday      = s1_req_r.wday;
    date_nxt.ctx.dim       = dim;
    date_nxt.ctx.pdim      = days_in_month(s1_req_r.month_sat - 4'd1, leap);
    if (s1_req_r.draw[DrawW-1]) begin
      date_nxt.ctx.lim = mag;
    end else if (s1_req_r.draw == 6'd0) begin
      date_nxt.ctx.lim = dim - DayW'(LastSpan);
    end else begin
      date_nxt.ctx.lim = s1_req_r.draw[DayW-1:0];
    end

    date_nxt.yy   = YyW'(s1_req_r.year) + YyW'(YearOffset) - YyW'(early);
    date_nxt.cent = s1_qy_r + QyW'(CentBias) - QyW'(early && (rem == 7'd0));
    date_nxt.mm   = early ? (s1_req_r.month_sat + 4'd9) : (s1_req_r.month_sat - 4'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_date_r <= date_nxt;
  end

  assign date_valid = s2_valid_r;
  assign date       = s2_date_r;

endmodule

`default_nettype wire

// ----- rtl/rdm_weekday.sv -----
// Day-number sum mod 7, first octal-digit fold registered.
`default_nettype none

module rdm_weekday (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         date_valid,
  input  rdm_pkg::rdm_date_t          date,
  output logic                        wk_valid,
  output rdm_pkg::rdm_wk_t            wk
);
  import rdm_pkg::*;

  logic [YyW-1:0]   wsum;
  logic [FoldW-1:0] fold_nxt;
  logic             s3_valid_r;
  rdm_wk_t          s3_wk_r;

  always_comb begin
    wsum = date.yy + (date.yy >> 2)
         + YyW'(date.cent >> 2) + (YyW'(CentPad) - YyW'(date.cent))
         + YyW'(month_term(date.mm)) + YyW'(date.ctx.lim) + YyW'(JdnAdj);
    // 8 = 1 mod 7: octal digit sum keeps the residue
    fold_nxt = FoldW'(wsum[2:0]) + FoldW'(wsum[5:3]) + FoldW'(wsum[8:6])
             + FoldW'(wsum[11:9]) + FoldW'(wsum[14:12]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_wk_r.ctx  <= date.ctx;
    s3_wk_r.fold <= fold_nxt;
  end

  assign wk_valid = s3_valid_r;
  assign wk       = s3_wk_r;

endmodule

`default_nettype wire

// ----- rtl/rdm_resolve.sv -----
// Weekday shift, month spill and result register.
`default_nettype none

module rdm_resolve (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wk_valid,
  input  rdm_pkg::rdm_wk_t            wk,
  output logic                        res_valid,
  output logic [rdm_pkg::MonthW-1:0]  res_month,
  output logic [rdm_pkg::DayW-1:0]    res_day
);
  import rdm_pkg::*;

  logic [3:0]        s2;
  logic [2:0]        wd0;
  logic [3:0]        t;
  logic [3:0]        shift;
  logic [5:0]        day_a;
  logic [MonthW-1:0] month_nxt;
  logic [DayW-1:0]   day_nxt;
  logic              valid_r;
  logic [MonthW-1:0] month_r;
  logic [DayW-1:0]   day_r;

  always_comb begin
    s2  = 4'(wk.fold[5:3]) + 4'(wk.fold[2:0]);
    wd0 = (s2 >= 4'(DaysPerWeek)) ? 3'(s2 - 4'(DaysPerWeek)) : s2[2:0];
    if (wk.ctx.backward) begin
      t = 4'(wd0) + 4'd8 - 4'(wk.ctx.wday);
    end else begin
      t = 4'(wk.ctx.wday) + 4'(LastSpan) - 4'(wd0);
    end
    shift = (t >= 4'(DaysPerWeek)) ? (t - 4'(DaysPerWeek)) : t;
    day_a = 6'(wk.ctx.lim) + 6'(shift);

    if (wk.ctx.exact) begin
      month_nxt = wk.ctx.month_in;
      day_nxt   = wk.ctx.draw_lo;
    end else if (wk.ctx.backward) begin
      if (5'(shift) < wk.ctx.lim) begin
        month_nxt = wk.ctx.month_sat;
        day_nxt   = wk.ctx.lim - 5'(shift);
      end else begin
        month_nxt = wk.ctx.month_sat - 4'd1;
        day_nxt   = 5'(6'(wk.ctx.lim) + 6'(wk.ctx.pdim) - 6'(shift));
      end
    end else begin
      if (day_a > 6'(wk.ctx.dim)) begin
        month_nxt = wk.ctx.month_sat + 4'd1;
        day_nxt   = 5'(day_a - 6'(wk.ctx.dim));
      end else begin
        month_nxt = wk.ctx.month_sat;
        day_nxt   = day_a[DayW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= wk_valid;
    end
  end

  always_ff @(posedge clk) begin
    month_r <= month_nxt;
    day_r   <= day_nxt;
  end

  assign res_valid = valid_r;
  assign res_month = month_r;
  assign res_day   = day_r;

endmodule

`default_nettype wire
